// File: rtl/skl_pkg.sv
// Package for the SQL keyword lexer: transaction types, token classes, character codes
// and the literal table used to recognise keywords and punctuation.
// Depends on nothing; every other file of the block imports it.
package skl_pkg;

    localparam int TOKEN_START_W = 10;
    localparam int TOKEN_INDEX_W = 7;
    localparam int TOKEN_COUNT_W = 8;
    localparam int WORD_LEN_W    = 8;
    localparam int NUM_LITS      = 8;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [WORD_LEN_W-1:0] WORD_LEN_MAX = '1;

    localparam logic [2:0] LIT_SELECT    = 3'd0;
    localparam logic [2:0] LIT_INSERT    = 3'd1;
    localparam logic [2:0] LIT_FROM      = 3'd2;
    localparam logic [2:0] LIT_INTO      = 3'd3;
    localparam logic [2:0] LIT_VALUES    = 3'd4;
    localparam logic [2:0] LIT_STAR      = 3'd5;
    localparam logic [2:0] LIT_COMMA     = 3'd6;
    localparam logic [2:0] LIT_SEMICOLON = 3'd7;

    typedef enum logic [3:0] {
        CLS_SELECT    = 4'd0,
        CLS_INSERT    = 4'd1,
        CLS_FROM      = 4'd2,
        CLS_INTO      = 4'd3,
        CLS_VALUES    = 4'd4,
        CLS_STRING    = 4'd5,
        CLS_STAR      = 4'd6,
        CLS_COMMA     = 4'd7,
        CLS_SEMICOLON = 4'd8,
        CLS_NUMBER    = 4'd9,
        CLS_UNKNOWN   = 4'd10,
        CLS_UNCLOSED  = 4'd11,
        CLS_TOO_LONG  = 4'd12
    } t_token_class;

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic                     token_valid;
        logic [3:0]               token_class;
        logic [TOKEN_START_W-1:0] token_start;
        logic [WORD_LEN_W-1:0]    byte_count;
        logic [TOKEN_INDEX_W-1:0] word_number;
        logic                     line_done;
        logic [TOKEN_COUNT_W-1:0] token_count;
        logic                     count_overflow;
    } t_out_item;

    typedef struct packed {
        logic      emit;
        t_out_item item;
    } t_core_result;

    // Literal text, left-aligned and padded with spaces beyond its length.
    function automatic logic [47:0] lit_text(input logic [2:0] k);
        logic [47:0] s;
        case (k)
            LIT_SELECT:    s = "select";
            LIT_INSERT:    s = "insert";
            LIT_FROM:      s = "from  ";
            LIT_INTO:      s = "into  ";
            LIT_VALUES:    s = "values";
            LIT_STAR:      s = "*     ";
            LIT_COMMA:     s = ",     ";
            LIT_SEMICOLON: s = ";     ";
            default:       s = "      ";
        endcase
        return s;
    endfunction

    function automatic logic [2:0] lit_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            LIT_SELECT, LIT_INSERT, LIT_VALUES: n = 3'd6;
            LIT_FROM, LIT_INTO:                 n = 3'd4;
            default:                            n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] lit_byte(input logic [2:0] k, input logic [2:0] pos);
        logic [47:0] s;
        logic [5:0]  sh;
        s  = lit_text(k);
        sh = 6'(pos) << 3;
        return 8'(s >> (6'd40 - sh));
    endfunction

    function automatic logic lit_hit(input logic [NUM_LITS-1:0] live,
                                     input logic [WORD_LEN_W-1:0] len,
                                     input logic [2:0] k);
        return live[k] && (len == WORD_LEN_W'(lit_len(k)));
    endfunction

    function automatic t_token_class classify(
        input logic                  quoted,
        input logic                  too_long,
        input logic [NUM_LITS-1:0]   live,
        input logic [WORD_LEN_W-1:0] len,
        input logic                  first_q,
        input logic                  last_q,
        input logic                  digits
    );
        t_token_class c;
        if (quoted) begin
            c = CLS_UNCLOSED;
        end else if (too_long) begin
            c = CLS_TOO_LONG;
        end else if (lit_hit(live, len, LIT_SELECT)) begin
            c = CLS_SELECT;
        end else if (lit_hit(live, len, LIT_INSERT)) begin
            c = CLS_INSERT;
        end else if (lit_hit(live, len, LIT_FROM)) begin
            c = CLS_FROM;
        end else if (lit_hit(live, len, LIT_INTO)) begin
            c = CLS_INTO;
        end else if (lit_hit(live, len, LIT_VALUES)) begin
            c = CLS_VALUES;
        end else if (first_q && last_q && len >= WORD_LEN_W'(2)) begin
            c = CLS_STRING;
        end else if (lit_hit(live, len, LIT_STAR)) begin
            c = CLS_STAR;
        end else if (lit_hit(live, len, LIT_COMMA)) begin
            c = CLS_COMMA;
        end else if (lit_hit(live, len, LIT_SEMICOLON)) begin
            c = CLS_SEMICOLON;
        end else if (digits && len != '0) begin
            c = CLS_NUMBER;
        end else begin
            c = CLS_UNKNOWN;
        end
        return c;
    endfunction

endpackage

// File: rtl/skl_core.sv
// Per-byte lexer core: holds the line and word state, advances it by one byte per
// transaction and forms the result for a finished word or the end of a line.
// Depends on skl_pkg.
module skl_core #(
    parameter int LINE_LEN      = 1024,
    parameter int MAX_TOKENS    = 128,
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  skl_pkg::t_in_item     i_item,
    output skl_pkg::t_core_result o_result
);
    import skl_pkg::*;

    localparam int LPW = $clog2(LINE_LEN);
    localparam int WSW = $clog2(MAX_TOKENS + 1);

    logic                  r_in_word, n_in_word;
    logic                  r_in_quoted, n_in_quoted;
    logic [LPW-1:0]        r_line_pos, n_line_pos;
    logic [LPW-1:0]        r_word_begin, n_word_begin;
    logic [WORD_LEN_W-1:0] r_word_len, n_word_len;
    logic                  r_too_long, n_too_long;
    logic [WSW-1:0]        r_words_seen, n_words_seen;
    logic [NUM_LITS-1:0]   r_lit_live, n_lit_live;
    logic                  r_first_q, n_first_q;
    logic                  r_last_q, n_last_q;
    logic                  r_all_digits, n_all_digits;
    logic                  r_overflowed, n_overflowed;

    logic       is_space;
    logic       is_quote;
    logic [7:0] lc;
    logic       do_begin;
    logic       do_add;
    logic       word_done;
    logic       room;

    always_comb begin
        n_in_word    = r_in_word;
        n_in_quoted  = r_in_quoted;
        n_line_pos   = r_line_pos;
        n_word_begin = r_word_begin;
        n_word_len   = r_word_len;
        n_too_long   = r_too_long;
        n_words_seen = r_words_seen;
        n_lit_live   = r_lit_live;
        n_first_q    = r_first_q;
        n_last_q     = r_last_q;
        n_all_digits = r_all_digits;
        n_overflowed = r_overflowed;
        o_result     = '0;

        is_space = (i_item.char_in == CHAR_SPACE);
        is_quote = (i_item.char_in == CHAR_QUOTE);
        lc       = i_item.char_in;
        if (i_item.char_in >= CHAR_UPPER_A && i_item.char_in <= CHAR_UPPER_Z) begin
            lc = i_item.char_in + CASE_OFFSET;
        end

        do_begin = !r_in_quoted && (is_quote || (!is_space && !r_in_word));
        do_add   = r_in_quoted || !is_space;

        if (do_begin) begin
            n_in_word    = 1'b1;
            n_word_begin = r_line_pos;
            n_word_len   = '0;
            n_too_long   = 1'b0;
            n_lit_live   = '1;
            n_first_q    = is_quote;
            n_last_q     = 1'b0;
            n_all_digits = 1'b1;
        end
        if (!r_in_quoted && is_quote) begin
            n_in_quoted = 1'b1;
        end

        if (do_add) begin
            for (int k = 0; k < NUM_LITS; k++) begin
                if (!(n_word_len < WORD_LEN_W'(lit_len(3'(k)))
                      && lit_byte(3'(k), n_word_len[2:0]) == lc)) begin
                    n_lit_live[k] = 1'b0;
                end
            end
            if (i_item.char_in < CHAR_DIGIT_0 || i_item.char_in > CHAR_DIGIT_9) begin
                n_all_digits = 1'b0;
            end
            n_last_q = is_quote;
            if (n_word_len >= WORD_LEN_W'(MAX_TOKEN_LEN)) begin
                n_too_long = 1'b1;
            end
            if (n_word_len != WORD_LEN_MAX) begin
                n_word_len = n_word_len + WORD_LEN_W'(1);
            end
        end
        if (r_in_quoted && is_quote) begin
            n_in_quoted = 1'b0;
        end

        if (r_line_pos < LPW'(LINE_LEN - 1)) begin
            n_line_pos = r_line_pos + LPW'(1);
        end

        word_done = ((!r_in_quoted && is_space) || i_item.line_end) && n_in_word;
        room      = (r_words_seen < WSW'(MAX_TOKENS));

        if (word_done && room) begin
            o_result.item.token_valid = 1'b1;
            o_result.item.token_class = classify(n_in_quoted, n_too_long, n_lit_live,
                                                 n_word_len, n_first_q, n_last_q,
                                                 n_all_digits);
            o_result.item.token_start = TOKEN_START_W'(n_word_begin);
            o_result.item.byte_count  = n_word_len;
            o_result.item.word_number = TOKEN_INDEX_W'(r_words_seen);
            n_words_seen = r_words_seen + WSW'(1);
        end else if (word_done) begin
            n_overflowed = 1'b1;
        end
        if (word_done) begin
            n_in_word   = 1'b0;
            n_in_quoted = 1'b0;
        end

        if (i_item.line_end) begin
            o_result.item.line_done      = 1'b1;
            o_result.item.token_count    = TOKEN_COUNT_W'(n_words_seen);
            o_result.item.count_overflow = n_overflowed;
            n_in_word    = 1'b0;
            n_in_quoted  = 1'b0;
            n_line_pos   = '0;
            n_word_begin = '0;
            n_word_len   = '0;
            n_too_long   = 1'b0;
            n_words_seen = '0;
            n_lit_live   = '1;
            n_first_q    = 1'b0;
            n_last_q     = 1'b0;
            n_all_digits = 1'b1;
            n_overflowed = 1'b0;
        end

        o_result.emit = o_result.item.token_valid || i_item.line_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word    <= 1'b0;
            r_in_quoted  <= 1'b0;
            r_line_pos   <= '0;
            r_word_begin <= '0;
            r_word_len   <= '0;
            r_too_long   <= 1'b0;
            r_words_seen <= '0;
            r_lit_live   <= '1;
            r_first_q    <= 1'b0;
            r_last_q     <= 1'b0;
            r_all_digits <= 1'b1;
            r_overflowed <= 1'b0;
        end else if (i_fire) begin
            r_in_word    <= n_in_word;
            r_in_quoted  <= n_in_quoted;
            r_line_pos   <= n_line_pos;
            r_word_begin <= n_word_begin;
            r_word_len   <= n_word_len;
            r_too_long   <= n_too_long;
            r_words_seen <= n_words_seen;
            r_lit_live   <= n_lit_live;
            r_first_q    <= n_first_q;
            r_last_q     <= n_last_q;
            r_all_digits <= n_all_digits;
            r_overflowed <= n_overflowed;
        end
    end

endmodule

// File: rtl/sql_keyword_lexer_top.sv
// Top level of the SQL keyword lexer: input register, lexer core and result register.
// Depends on skl_pkg and skl_core.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_ready    i_in_data  (skl_pkg::t_in_item)
//   out       output     o_out_valid / i_out_ready  o_out_data (skl_pkg::t_out_item)
//
// One byte is accepted per cycle for as long as results are taken.
// A result is presented from the result register: the byte that causes it is held first
// in the input register, then, when it advances, the core updates its state and loads
// the result register.
// A byte that ends no word and no line moves the state on without producing a result.
// While a result waits, the input register still takes one byte; further bytes stall.
// Reset empties both registers and returns the line state to the start of a line.
module sql_keyword_lexer_top #(
    parameter int LINE_LEN      = 1024,
    parameter int MAX_TOKENS    = 128,
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  skl_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output skl_pkg::t_out_item o_out_data
);
    import skl_pkg::*;

    logic         r_s1_valid;
    t_in_item     r_s1_item;
    logic         r_out_valid;
    t_out_item    r_out_item;
    logic         advance;
    t_core_result core_result;

    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;

    skl_core #(
        .LINE_LEN      (LINE_LEN),
        .MAX_TOKENS    (MAX_TOKENS),
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_s1_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_result.emit) begin
            r_out_item <= core_result.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

// File: rtl/skl_checker.sv
// Port-level checker for the SQL keyword lexer, bound to the top level.
// Depends on skl_pkg and sql_keyword_lexer_top.
module skl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input skl_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input skl_pkg::t_out_item o_out_data
);
    import skl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("Result transaction dropped or changed while stalled.");

    a_in_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input stalled although no result was waiting.");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.token_valid || o_out_data.line_done))
        else $error("Result transaction carries neither a word nor an end of line.");

    a_line_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.line_done |->
            (o_out_data.token_count == '0) && !o_out_data.count_overflow)
        else $error("Line summary present on a result that does not end the line.");

    a_word_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_valid |-> (o_out_data.byte_count != '0))
        else $error("Word result with zero length.");

endmodule

bind sql_keyword_lexer_top skl_checker u_skl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
